// ===== design/cpu_debug_monitor_unit_assert.svh =====
`ifndef CPU_DEBUG_MONITOR_UNIT_ASSERT_SVH
`define CPU_DEBUG_MONITOR_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define CDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define CDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cdm_pkg.sv =====
package cdm_pkg;

    // default configuration of the top level
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int ADDR_BITS_DEF   = 16;

    // breakpoint bitmap row: 32 flags per memory word
    localparam int BP_WORD_LOG2 = 5;
    localparam int BP_WORD_BITS = 1 << BP_WORD_LOG2;

    // fixed field widths
    localparam int KIND_W      = 3;
    localparam int OP_W        = 8;
    localparam int ADDR_OUT_W  = 16;
    localparam int DEPTH_OUT_W = 11;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RET  = 2'd2;

    // register reset values
    localparam logic [OP_W-1:0] BRK_OP_RST  = 8'h00;
    localparam logic [OP_W-1:0] CALL_OP_RST = 8'h20;
    localparam logic [OP_W-1:0] RET_OP_RST  = 8'h60;

    typedef enum logic [KIND_W-1:0] {
        KIND_FETCH     = 3'd0,
        KIND_BP_ADD    = 3'd1,
        KIND_BP_DEL    = 3'd2,
        KIND_STEP_INSN = 3'd3,
        KIND_STEP_SUB  = 3'd4,
        KIND_TGT_RESET = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_INSN = 2'd1,
        STEP_SUB  = 2'd2
    } t_step;

    // where the reported stack top comes from
    typedef enum logic [1:0] {
        TOP_ZERO = 2'd0,
        TOP_REG  = 2'd1,
        TOP_MEM  = 2'd2
    } t_top_src;

    typedef struct packed {
        logic                   run;
        logic                   stop;
        logic                   hit;
        logic                   fail;
        logic [DEPTH_OUT_W-1:0] depth;
        logic [ADDR_OUT_W-1:0]  top;
        t_step                  step;
    } t_result;

endpackage

// ===== design/cdm_bp_map.sv =====
module cdm_bp_map
    import cdm_pkg::*;
#(
    parameter int ROW_W = ADDR_BITS_DEF - BP_WORD_LOG2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [ROW_W-1:0]        i_rd_row,
    output logic [BP_WORD_BITS-1:0] o_rd_data,
    input  logic                    i_wr_en,
    input  logic [ROW_W-1:0]        i_wr_row,
    input  logic [BP_WORD_BITS-1:0] i_wr_data,
    output logic                    o_busy
);

    localparam int ROWS = 1 << ROW_W;

    logic [BP_WORD_BITS-1:0] r_mem [ROWS];
    logic [BP_WORD_BITS-1:0] r_rd_data;
    logic                    r_clr_busy;
    logic [ROW_W-1:0]        r_clr_row;

    // clearing pass after reset, one row a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // bitmap storage, read data registered
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_row] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// ===== design/cdm_ret_stack.sv =====
module cdm_ret_stack
    import cdm_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int WIDTH = ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // return address storage, read data registered
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/cpu_debug_monitor_unit.sv =====
// Debug monitor for a 6502-style CPU. Every input word (opcode fetch, breakpoint edit,
// step command or target reset) gives exactly one result word. The block takes one word
// per clock when the output side keeps up; a result is registered at acceptance into the
// second stage, with the breakpoint memory read, and then moves on into the output register.
// The breakpoint bitmap sits in a memory of 32-bit rows that is read at acceptance and
// written back as the word moves on to the output register, with the pending row
// forwarded to the next word. After reset the bitmap is swept clear, all 2^(ADDR_BITS-5)
// rows (2048 at the default width), with o_stall held high; the configuration port is
// always ready, also during the sweep. The shadow call stack holds STACK_DEPTH return
// addresses.
module cpu_debug_monitor_unit
    import cdm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [ADDR_OUT_W-1:0]  i_address,
    input  logic [OP_W-1:0]        i_opcode,
    // result words
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_run_request,
    output logic                   o_stop_request,
    output logic                   o_breakpoint_hit,
    output logic                   o_fail,
    output logic [DEPTH_OUT_W-1:0] o_call_depth,
    output logic [ADDR_OUT_W-1:0]  o_stack_top,
    output logic [1:0]             o_stepping,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [OP_W-1:0]        i_cfg_data
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH);
    localparam int ROW_W   = ADDR_BITS - BP_WORD_LOG2;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    // configuration registers
    logic [OP_W-1:0] r_brk_op;
    logic [OP_W-1:0] r_call_op;
    logic [OP_W-1:0] r_ret_op;

    // monitor state
    logic                 r_fail;
    logic [OP_W-1:0]      r_cur_op;
    logic [ADDR_BITS-1:0] r_cur_addr;
    t_step                r_step;
    logic [DEPTH_W-1:0]   r_saved;
    logic [DEPTH_W-1:0]   r_depth;

    logic                 n_fail;
    logic [OP_W-1:0]      n_cur_op;
    logic [ADDR_BITS-1:0] n_cur_addr;
    t_step                n_step;
    logic [DEPTH_W-1:0]   n_saved;
    logic [DEPTH_W-1:0]   n_depth;

    // first stage decisions
    logic                 a_run;
    logic                 a_stop;
    logic                 a_chk;
    logic                 a_bp_wr;
    logic                 a_bp_set;
    logic                 a_push;
    t_top_src             a_top_src;
    logic [DEPTH_W-1:0]   depth_m1;

    logic [ADDR_BITS+ADDR_OUT_W-1:0] addr_ext;
    logic [ADDR_BITS-1:0]            addr;

    // second stage
    logic                    r_b_vld;
    logic                    r_b_run;
    logic                    r_b_stop;
    logic                    r_b_chk;
    logic                    r_b_bp_wr;
    logic                    r_b_bp_set;
    logic [ROW_W-1:0]        r_b_row;
    logic [BP_WORD_LOG2-1:0] r_b_bit;
    logic                    r_b_fail;
    logic [DEPTH_W-1:0]      r_b_depth;
    t_top_src                r_b_top_src;
    logic [ADDR_BITS-1:0]    r_b_top_val;
    t_step                   r_b_step;
    logic                    r_b_fwd_vld;
    logic [ROW_W-1:0]        r_b_fwd_row;
    logic [BP_WORD_BITS-1:0] r_b_fwd_data;

    logic [BP_WORD_BITS-1:0] bp_q;
    logic [BP_WORD_BITS-1:0] bp_word;
    logic [BP_WORD_BITS-1:0] bp_new;
    logic                    bp_wr_en;
    logic                    bp_busy;
    logic [ADDR_BITS-1:0]    stk_q;
    logic [ADDR_BITS-1:0]    b_top;
    logic [ADDR_BITS+ADDR_OUT_W-1:0] top_ext;
    logic [DEPTH_W+DEPTH_OUT_W-1:0]  depth_ext;
    t_result                 b_res;

    // output register
    logic    r_out_vld;
    t_result r_out;

    logic in_acc;
    logic b_move;

    // handshake
    assign b_move  = r_b_vld && (!r_out_vld || !i_stall);
    assign o_stall = bp_busy || (r_b_vld && !b_move);
    assign in_acc  = i_valid && !o_stall;

    // fetch address reduced to the address width
    assign addr_ext = {{ADDR_BITS{1'b0}}, i_address};
    assign addr     = addr_ext[ADDR_BITS-1:0];

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk_op  <= BRK_OP_RST;
            r_call_op <= CALL_OP_RST;
            r_ret_op  <= RET_OP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BRK:  r_brk_op  <= i_cfg_data;
                CFG_CALL: r_call_op <= i_cfg_data;
                CFG_RET:  r_ret_op  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state of the monitor for the word at the input
    always_comb begin
        n_fail     = r_fail;
        n_cur_op   = r_cur_op;
        n_cur_addr = r_cur_addr;
        n_step     = r_step;
        n_saved    = r_saved;
        n_depth    = r_depth;
        a_run      = 1'b0;
        a_stop     = 1'b0;
        a_chk      = 1'b0;
        a_bp_wr    = 1'b0;
        a_bp_set   = 1'b0;
        a_push     = 1'b0;
        unique case (t_kind'(i_kind))
            KIND_FETCH: begin
                if (!r_fail) begin
                    n_cur_op   = i_opcode;
                    n_cur_addr = addr;
                    a_chk      = 1'b1;
                    // the instruction before this fetch decides push or pop
                    if (r_cur_op == r_call_op) begin
                        if (r_depth == DEPTH_FULL) begin
                            n_fail = 1'b1;
                            a_stop = 1'b1;
                            n_step = STEP_NONE;
                        end else begin
                            a_push  = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end
                    end else if (r_cur_op == r_ret_op) begin
                        if (r_depth == '0) begin
                            n_fail = 1'b1;
                            a_stop = 1'b1;
                            n_step = STEP_NONE;
                        end else begin
                            n_depth = r_depth - 1'b1;
                        end
                    end
                    // single step ends on any fetch
                    if (n_step == STEP_INSN) begin
                        a_stop = 1'b1;
                        n_step = STEP_NONE;
                    end
                    // step-over ends on a break or a return to the saved depth
                    if (n_step == STEP_SUB && (r_cur_op == r_brk_op ||
                            (r_cur_op == r_ret_op && n_depth == r_saved))) begin
                        a_stop = 1'b1;
                        n_step = STEP_NONE;
                    end
                end
            end
            KIND_BP_ADD: begin
                a_bp_wr  = 1'b1;
                a_bp_set = 1'b1;
            end
            KIND_BP_DEL: begin
                a_bp_wr = 1'b1;
            end
            KIND_STEP_INSN: begin
                n_step = STEP_INSN;
                a_run  = 1'b1;
            end
            KIND_STEP_SUB: begin
                if (r_cur_op == r_call_op) begin
                    n_step  = STEP_SUB;
                    n_saved = r_depth;
                end else begin
                    n_step = STEP_INSN;
                end
                a_run = 1'b1;
            end
            KIND_TGT_RESET: begin
                n_fail     = 1'b0;
                n_cur_op   = '0;
                n_cur_addr = '0;
                n_depth    = '0;
                n_saved    = '0;
            end
            default: ;
        endcase
    end

    // stack top source: zero for an empty stack, pushed value is forwarded, otherwise read from the stack
    assign depth_m1 = n_depth - 1'b1;

    always_comb begin
        if (n_depth == '0) begin
            a_top_src = TOP_ZERO;
        end else if (a_push) begin
            a_top_src = TOP_REG;
        end else begin
            a_top_src = TOP_MEM;
        end
    end

    // monitor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail     <= 1'b0;
            r_cur_op   <= '0;
            r_cur_addr <= '0;
            r_step     <= STEP_NONE;
            r_saved    <= '0;
            r_depth    <= '0;
        end else if (in_acc) begin
            r_fail     <= n_fail;
            r_cur_op   <= n_cur_op;
            r_cur_addr <= n_cur_addr;
            r_step     <= n_step;
            r_saved    <= n_saved;
            r_depth    <= n_depth;
        end
    end

    // second stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (in_acc) begin
            r_b_vld <= 1'b1;
        end else if (b_move) begin
            r_b_vld <= 1'b0;
        end
    end

    // second stage payload, with the bitmap row written back at this same edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_run      <= a_run;
            r_b_stop     <= a_stop;
            r_b_chk      <= a_chk;
            r_b_bp_wr    <= a_bp_wr;
            r_b_bp_set   <= a_bp_set;
            r_b_row      <= addr[ADDR_BITS-1:BP_WORD_LOG2];
            r_b_bit      <= addr[BP_WORD_LOG2-1:0];
            r_b_fail     <= n_fail;
            r_b_depth    <= n_depth;
            r_b_top_src  <= a_top_src;
            r_b_top_val  <= r_cur_addr;
            r_b_step     <= n_step;
            r_b_fwd_vld  <= bp_wr_en;
            r_b_fwd_row  <= r_b_row;
            r_b_fwd_data <= bp_new;
        end
    end

    // breakpoint bitmap
    cdm_bp_map #(
        .ROW_W (ROW_W)
    ) u_bp_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_row  (addr[ADDR_BITS-1:BP_WORD_LOG2]),
        .o_rd_data (bp_q),
        .i_wr_en   (bp_wr_en),
        .i_wr_row  (r_b_row),
        .i_wr_data (bp_new),
        .o_busy    (bp_busy)
    );

    // shadow call stack
    cdm_ret_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ADDR_BITS)
    ) u_ret_stack (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && a_push),
        .i_wr_addr (r_depth[SP_W-1:0]),
        .i_wr_data (r_cur_addr),
        .i_rd_en   (in_acc),
        .i_rd_addr (depth_m1[SP_W-1:0]),
        .o_rd_data (stk_q)
    );

    // bitmap row with the row written at acceptance forwarded
    always_comb begin
        if (r_b_fwd_vld && r_b_fwd_row == r_b_row) begin
            bp_word = r_b_fwd_data;
        end else begin
            bp_word = bp_q;
        end
        bp_new          = bp_word;
        bp_new[r_b_bit] = r_b_bp_set;
    end

    assign bp_wr_en = b_move && r_b_bp_wr;

    // stack top selection
    always_comb begin
        unique case (r_b_top_src)
            TOP_REG: b_top = r_b_top_val;
            TOP_MEM: b_top = stk_q;
            default: b_top = '0;
        endcase
    end

    assign top_ext   = {{ADDR_OUT_W{1'b0}}, b_top};
    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, r_b_depth};

    // result word
    always_comb begin
        b_res.run   = r_b_run;
        b_res.hit   = r_b_chk && bp_word[r_b_bit];
        b_res.stop  = r_b_stop || b_res.hit;
        b_res.fail  = r_b_fail;
        b_res.depth = depth_ext[DEPTH_OUT_W-1:0];
        b_res.top   = top_ext[ADDR_OUT_W-1:0];
        b_res.step  = r_b_step;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (b_move) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_out <= b_res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_run_request    = r_out.run;
    assign o_stop_request   = r_out.stop;
    assign o_breakpoint_hit = r_out.hit;
    assign o_fail           = r_out.fail;
    assign o_call_depth     = r_out.depth;
    assign o_stack_top      = r_out.top;
    assign o_stepping       = r_out.step;

endmodule

// ===== design/cdm_checker.sv =====
`include "cpu_debug_monitor_unit_assert.svh"

module cdm_checker
    import cdm_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_run_request,
    input logic                   o_stop_request,
    input logic                   o_breakpoint_hit,
    input logic [DEPTH_OUT_W-1:0] o_call_depth,
    input logic [ADDR_OUT_W-1:0]  o_stack_top
);

    // a stalled result word stays offered
    `CDM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result word dropped while stalled")

    // start and halt never asked for by the same word
    `CDM_ASSERT_NOW(a_run_stop, i_clk, i_rst_n, o_valid, !(o_run_request && o_stop_request), "run and stop requested together")

    // a breakpoint hit always halts
    `CDM_ASSERT_NOW(a_hit_stop, i_clk, i_rst_n, o_valid && o_breakpoint_hit, o_stop_request, "breakpoint hit without stop request")

    // an empty stack reports a zero top (checked only for STACK_DEPTH below 2048)
    `CDM_ASSERT_NOW(a_empty_top, i_clk, i_rst_n, o_valid && o_call_depth == '0, (STACK_DEPTH >= 2048) || o_stack_top == '0, "empty stack with nonzero top")

endmodule

bind cpu_debug_monitor_unit cdm_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_cdm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_run_request    (o_run_request),
    .o_stop_request   (o_stop_request),
    .o_breakpoint_hit (o_breakpoint_hit),
    .o_call_depth     (o_call_depth),
    .o_stack_top      (o_stack_top)
);
